// ----- hdl/command_frame_checker_with_reply_top_assert.svh -----
// assertion macros for the command frame checker and its bound checker
`ifndef COMMAND_FRAME_CHECKER_WITH_REPLY_TOP_ASSERT_SVH
`define COMMAND_FRAME_CHECKER_WITH_REPLY_TOP_ASSERT_SVH

// property checked only outside reset
`define CFCR_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CFCR_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/cfcr_pkg.sv -----
// shared types and constants of the command frame checker
package cfcr_pkg;

    localparam int unsigned FRAME_BYTES = 10;
    localparam int unsigned POS_W       = 4;

    // frame header bytes
    localparam logic [7:0] HEAD0 = 8'h5E;
    localparam logic [7:0] HEAD1 = 8'h0C;

    // byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HEAD0  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HEAD1  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_NODE   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CMD    = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PRIO   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_X_HI   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_X_LO   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_Y_HI   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_Y_LO   = POS_W'(7);
    localparam logic [POS_W-1:0] POS_CHK_HI = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_IDLE   = POS_W'(FRAME_BYTES);

    typedef enum logic [2:0] {
        KIND_TASK    = 3'd0,
        KIND_AVOID   = 3'd1,
        KIND_STOP    = 3'd2,
        KIND_ADVANCE = 3'd3,
        KIND_UNKNOWN = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CFG_NODE_ID    = 3'd0,
        CFG_PRIORITY   = 3'd1,
        CFG_TASK_OP    = 3'd2,
        CFG_AVOID_OP   = 3'd3,
        CFG_STOP_OP    = 3'd4,
        CFG_ADVANCE_OP = 3'd5,
        CFG_REPLY_OP   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] node_id;
        logic [7:0] priority_level;
        logic [7:0] task_opcode;
        logic [7:0] avoid_opcode;
        logic [7:0] stop_opcode;
        logic [7:0] advance_opcode;
        logic [7:0] reply_opcode;
    } t_cfg;

    // one reply waiting to be sent
    typedef struct packed {
        logic [7:0]  node_id;
        logic [7:0]  reply_opcode;
        logic [7:0]  priority_level;
        logic [15:0] reply_sum;
        t_kind       kind;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ----- hdl/cfcr_front.sv -----
// frame parser: tracks position, checksum and header, queues a reply job
module cfcr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_frame_start,
    input  cfcr_pkg::t_cfg i_cfg,
    output logic           o_push,
    output cfcr_pkg::t_job o_job
);
    import cfcr_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_sum, n_sum;
    logic             r_prefix_ok, n_prefix_ok;
    logic [7:0]       r_cmd, n_cmd;
    logic [15:0]      r_x, n_x;
    logic [15:0]      r_y, n_y;
    logic [7:0]       r_chk_hi, n_chk_hi;

    logic [POS_W-1:0] w_pos;
    logic             w_active;
    logic             w_good;
    t_kind            w_kind;

    // a start beat always restarts the frame
    assign w_pos    = i_frame_start ? POS_HEAD0 : r_pos;
    assign w_active = i_valid && (w_pos < POS_IDLE);

    // frame is good on its last beat when header, id and checksum agree
    assign w_good = w_active && (w_pos == POS_LAST) && r_prefix_ok
                    && ({r_chk_hi, i_rx_byte} == r_sum);

    // command decode, first match wins
    always_comb begin
        priority if (r_cmd == i_cfg.task_opcode) begin
            w_kind = KIND_TASK;
        end else if (r_cmd == i_cfg.avoid_opcode) begin
            w_kind = KIND_AVOID;
        end else if (r_cmd == i_cfg.stop_opcode) begin
            w_kind = KIND_STOP;
        end else if (r_cmd == i_cfg.advance_opcode) begin
            w_kind = KIND_ADVANCE;
        end else begin
            w_kind = KIND_UNKNOWN;
        end
    end

    // per-position field capture
    always_comb begin
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_prefix_ok = r_prefix_ok;
        n_cmd       = r_cmd;
        n_x         = r_x;
        n_y         = r_y;
        n_chk_hi    = r_chk_hi;
        if (w_active) begin
            n_pos = w_pos + POS_W'(1);
            if (w_pos < POS_CHK_HI) begin
                n_sum = (w_pos == POS_HEAD0) ? {8'h00, i_rx_byte}
                                             : r_sum + {8'h00, i_rx_byte};
            end
            unique case (w_pos)
                POS_HEAD0:  n_prefix_ok = (i_rx_byte == HEAD0);
                POS_HEAD1:  n_prefix_ok = r_prefix_ok && (i_rx_byte == HEAD1);
                POS_NODE:   n_prefix_ok = r_prefix_ok && (i_rx_byte == i_cfg.node_id);
                POS_CMD:    n_cmd = i_rx_byte;
                POS_X_HI:   n_x = {i_rx_byte, r_x[7:0]};
                POS_X_LO:   n_x = {r_x[15:8], i_rx_byte};
                POS_Y_HI:   n_y = {i_rx_byte, r_y[7:0]};
                POS_Y_LO:   n_y = {r_y[15:8], i_rx_byte};
                POS_CHK_HI: n_chk_hi = i_rx_byte;
                default: begin
                end
            endcase
        end
    end

    // parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_IDLE;
            r_prefix_ok <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_prefix_ok <= n_prefix_ok;
        end
        r_sum    <= n_sum;
        r_cmd    <= n_cmd;
        r_x      <= n_x;
        r_y      <= n_y;
        r_chk_hi <= n_chk_hi;
    end

    // reply job, register values as of the last frame beat
    assign o_push               = w_good;
    assign o_job.node_id        = i_cfg.node_id;
    assign o_job.reply_opcode   = i_cfg.reply_opcode;
    assign o_job.priority_level = i_cfg.priority_level;
    assign o_job.reply_sum      = {8'h00, HEAD0} + {8'h00, HEAD1}
                                  + {8'h00, i_cfg.node_id}
                                  + {8'h00, i_cfg.reply_opcode}
                                  + {8'h00, i_cfg.priority_level};
    assign o_job.kind           = w_kind;
    assign o_job.coord_x        = r_x;
    assign o_job.coord_y        = r_y;

endmodule

// ----- hdl/cfcr_job_fifo.sv -----
// small register queue of reply jobs between parser and sender
module cfcr_job_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cfcr_pkg::t_job    i_job,
    input  logic              i_pop,
    output cfcr_pkg::t_job    o_head,
    output cfcr_pkg::t_q_stat o_stat
);
    import cfcr_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr, w_rd;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_FULL);
    assign w_wr = i_push && !o_stat.full;
    assign w_rd = i_pop && !o_stat.empty;
    assign o_head = r_mem[r_rp];

    // pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == PTR_LAST) ? '0 : r_wp + PW'(1);
        end
        if (w_rd) begin
            n_rp = (r_rp == PTR_LAST) ? '0 : r_rp + PW'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ----- hdl/cfcr_back.sv -----
// reply sender: walks the head job through its ten bytes into an output register
module cfcr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfcr_pkg::t_job    i_head,
    input  cfcr_pkg::t_q_stat i_stat,
    output logic              o_job_pop,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [7:0]        o_tx_byte,
    output logic              o_tx_last,
    output logic [2:0]        o_command_kind,
    output logic [15:0]       o_coord_x,
    output logic [15:0]       o_coord_y
);
    import cfcr_pkg::*;

    logic [POS_W-1:0] r_idx, n_idx;
    logic             r_valid, n_valid;
    logic [7:0]       r_tx_byte;
    logic             r_tx_last;
    logic [2:0]       r_kind;
    logic [15:0]      r_x, r_y;

    logic             w_adv;
    logic             w_last;
    logic [7:0]       w_byte;

    // load a new beat when the output register is free or being taken
    assign w_adv  = !i_stat.empty && (!r_valid || i_pop);
    assign w_last = (r_idx == POS_LAST);
    assign o_job_pop = w_adv && w_last;

    // reply byte for the current index
    always_comb begin
        unique case (r_idx)
            POS_HEAD0:  w_byte = HEAD0;
            POS_HEAD1:  w_byte = HEAD1;
            POS_NODE:   w_byte = i_head.node_id;
            POS_CMD:    w_byte = i_head.reply_opcode;
            POS_PRIO:   w_byte = i_head.priority_level;
            POS_CHK_HI: w_byte = i_head.reply_sum[15:8];
            POS_LAST:   w_byte = i_head.reply_sum[7:0];
            default:    w_byte = 8'h00;
        endcase
    end

    // index and output valid
    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (w_adv) begin
            n_idx   = w_last ? POS_HEAD0 : r_idx + POS_W'(1);
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= POS_HEAD0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tx_byte <= w_byte;
            r_tx_last <= w_last;
            r_kind    <= i_head.kind;
            r_x       <= i_head.coord_x;
            r_y       <= i_head.coord_y;
        end
    end

    assign o_valid        = r_valid;
    assign o_tx_byte      = r_tx_byte;
    assign o_tx_last      = r_tx_last;
    assign o_command_kind = r_kind;
    assign o_coord_x      = r_x;
    assign o_coord_y      = r_y;

endmodule

// ----- hdl/command_frame_checker_with_reply_top.sv -----
// top level of the command frame checker with reply
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+---------------------------------------
//  rx bytes  | in        | push / full          | i_rx_byte, i_frame_start
//  reply     | out       | pop / empty          | o_tx_byte, o_tx_last, o_command_kind,
//            |           |                      | o_coord_x, o_coord_y
//  config    | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// one received byte is taken per cycle; the parser never waits on the sender
// except when JOB_DEPTH replies are already queued, which raises full
// a good frame gives ten reply beats, one per cycle while pop is held, with the
// first beat going through the reply queue and then the output beat register
// reset is synchronous and active low; it empties the reply queue and idles the
// parser until the next start byte
module command_frame_checker_with_reply_top #(
    parameter int unsigned JOB_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic [2:0]  o_command_kind,
    output logic [15:0] o_coord_x,
    output logic [15:0] o_coord_y,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import cfcr_pkg::*;

    t_cfg    r_cfg;
    t_job    w_front_job, w_head;
    t_q_stat w_q_stat;
    logic    w_front_push;
    logic    w_job_pop;
    logic    w_out_valid;
    logic    w_in_beat;

    assign w_in_beat = push && !full;
    assign full      = w_q_stat.full;
    assign empty     = !w_out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_id        <= 8'd0;
            r_cfg.priority_level <= 8'd0;
            r_cfg.task_opcode    <= 8'd0;
            r_cfg.avoid_opcode   <= 8'd1;
            r_cfg.stop_opcode    <= 8'd2;
            r_cfg.advance_opcode <= 8'd3;
            r_cfg.reply_opcode   <= 8'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_ID:    r_cfg.node_id        <= i_cfg_data;
                CFG_PRIORITY:   r_cfg.priority_level <= i_cfg_data;
                CFG_TASK_OP:    r_cfg.task_opcode    <= i_cfg_data;
                CFG_AVOID_OP:   r_cfg.avoid_opcode   <= i_cfg_data;
                CFG_STOP_OP:    r_cfg.stop_opcode    <= i_cfg_data;
                CFG_ADVANCE_OP: r_cfg.advance_opcode <= i_cfg_data;
                CFG_REPLY_OP:   r_cfg.reply_opcode   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // frame parser
    cfcr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_in_beat),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .i_cfg         (r_cfg),
        .o_push        (w_front_push),
        .o_job         (w_front_job)
    );

    // reply job queue
    cfcr_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_job   (w_front_job),
        .i_pop   (w_job_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // reply sender
    cfcr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_stat         (w_q_stat),
        .o_job_pop      (w_job_pop),
        .o_valid        (w_out_valid),
        .i_pop          (pop),
        .o_tx_byte      (o_tx_byte),
        .o_tx_last      (o_tx_last),
        .o_command_kind (o_command_kind),
        .o_coord_x      (o_coord_x),
        .o_coord_y      (o_coord_y)
    );

endmodule

// ----- hdl/cfcr_checker.sv -----
// port-level checks of the command frame checker, bound to the top level
`include "command_frame_checker_with_reply_top_assert.svh"

module cfcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_tx_byte,
    input logic        o_tx_last,
    input logic [2:0]  o_command_kind
);
    import cfcr_pkg::*;

    // reset leaves no reply beat and room for input
    `CFCR_ASSERT_ALL(a_reset_idle, i_clk, !i_rst_n |=> (empty && !full), "not idle after reset")

    // a waiting reply beat holds until taken
    `CFCR_ASSERT_RUN(a_beat_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_tx_byte) && $stable(o_tx_last)), "reply beat changed while stalled")

    // a reply burst has no gaps once started
    `CFCR_ASSERT_RUN(a_no_gap, i_clk, i_rst_n, (!empty && pop && !o_tx_last) |=> !empty, "gap inside a reply burst")

    // decoded command stays within its codes
    `CFCR_ASSERT_RUN(a_kind_range, i_clk, i_rst_n, !empty |-> (o_command_kind <= KIND_UNKNOWN), "command kind out of range")

endmodule

bind command_frame_checker_with_reply_top cfcr_checker u_cfcr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_tx_byte      (o_tx_byte),
    .o_tx_last      (o_tx_last),
    .o_command_kind (o_command_kind)
);
